/* rtl/core/mmgps_pkg.sv */
// ----------------------------------------------------------------------------
// mmgps_pkg
// Shared constants, state encoding and controller/datapath interface types
// for the max-min gap placement search.
// ----------------------------------------------------------------------------
`default_nettype none

package mmgps_pkg;

  localparam int MAX_POINTS = 1024;
  localparam int ADDR_W     = $clog2(MAX_POINTS);
  localparam int CNT_W      = ADDR_W + 1;
  localparam int POS_W      = 30;
  localparam int COW_W      = 11;
  localparam int BOUND_W    = 32;
  localparam int GAP_LIMIT  = 1000000000;
  localparam int COW_RESET  = 2;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_INS_RD,
    ST_INS_CMP,
    ST_FIN,
    ST_SRCH_CHK,
    ST_P_START,
    ST_P_FIRST,
    ST_P_RUN,
    ST_P_END,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic accept;      // latch the incoming transaction
    logic ins_start;   // k <= point total
    logic ins_rd;      // read entry k-1
    logic ins_shift;   // move read entry up to k, step k down
    logic ins_place;   // write new position at k, count it
    logic search_init; // reset bounds
    logic mid_load;    // compute next probe gap
    logic pass_start;  // read entry 0, k <= 1
    logic pass_first;  // take entry 0 as first placement
    logic pass_run;    // greedy test on the returned entry
    logic pass_adv;    // read entry k, step k up
    logic pass_end;    // narrow the bounds
    logic set_none;    // result: no solution
    logic set_gap;     // result: gap from the bounds
    logic clear_total; // data set done
  } cmd_t;

  typedef struct packed {
    logic full;
    logic k_zero;
    logic rd_gt_pos;
    logic last;
    logic cow_gt_total;
    logic low_le_high;
    logic more;
  } status_t;

endpackage

`default_nettype wire

/* rtl/core/mmgps_ram.sv */
// ----------------------------------------------------------------------------
// mmgps_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module mmgps_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

/* rtl/core/mmgps_ctrl.sv */
// ----------------------------------------------------------------------------
// mmgps_ctrl
// Sequencer: insertion on load, then binary search over greedy passes.
// ----------------------------------------------------------------------------
`default_nettype none

module mmgps_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  input  wire mmgps_pkg::status_t sts_i,
  output mmgps_pkg::cmd_t        cmd_o
);

  mmgps_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mmgps_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    in_stall_o  = 1'b1;
    out_valid_o = 1'b0;
    case (state_q)
      mmgps_pkg::ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.accept    = 1'b1;
          cmd_o.ins_start = 1'b1;
          state_d         = mmgps_pkg::ST_INS_RD;
        end
      end
      mmgps_pkg::ST_INS_RD: begin
        // A full store drops the position; last still closes the set.
        if (sts_i.full) begin
          state_d = sts_i.last ? mmgps_pkg::ST_FIN : mmgps_pkg::ST_IDLE;
        end else if (sts_i.k_zero) begin
          cmd_o.ins_place = 1'b1;
          state_d = sts_i.last ? mmgps_pkg::ST_FIN : mmgps_pkg::ST_IDLE;
        end else begin
          cmd_o.ins_rd = 1'b1;
          state_d      = mmgps_pkg::ST_INS_CMP;
        end
      end
      mmgps_pkg::ST_INS_CMP: begin
        if (sts_i.rd_gt_pos) begin
          cmd_o.ins_shift = 1'b1;
          state_d         = mmgps_pkg::ST_INS_RD;
        end else begin
          cmd_o.ins_place = 1'b1;
          state_d = sts_i.last ? mmgps_pkg::ST_FIN : mmgps_pkg::ST_IDLE;
        end
      end
      mmgps_pkg::ST_FIN: begin
        if (sts_i.cow_gt_total) begin
          cmd_o.set_none = 1'b1;
          state_d        = mmgps_pkg::ST_OUT;
        end else begin
          cmd_o.search_init = 1'b1;
          state_d           = mmgps_pkg::ST_SRCH_CHK;
        end
      end
      mmgps_pkg::ST_SRCH_CHK: begin
        if (sts_i.low_le_high) begin
          cmd_o.mid_load = 1'b1;
          state_d        = mmgps_pkg::ST_P_START;
        end else begin
          cmd_o.set_gap = 1'b1;
          state_d       = mmgps_pkg::ST_OUT;
        end
      end
      mmgps_pkg::ST_P_START: begin
        cmd_o.pass_start = 1'b1;
        state_d          = mmgps_pkg::ST_P_FIRST;
      end
      mmgps_pkg::ST_P_FIRST: begin
        cmd_o.pass_first = 1'b1;
        if (sts_i.more) begin
          cmd_o.pass_adv = 1'b1;
          state_d        = mmgps_pkg::ST_P_RUN;
        end else begin
          state_d = mmgps_pkg::ST_P_END;
        end
      end
      mmgps_pkg::ST_P_RUN: begin
        cmd_o.pass_run = 1'b1;
        if (sts_i.more) begin
          cmd_o.pass_adv = 1'b1;
        end else begin
          state_d = mmgps_pkg::ST_P_END;
        end
      end
      mmgps_pkg::ST_P_END: begin
        cmd_o.pass_end = 1'b1;
        state_d        = mmgps_pkg::ST_SRCH_CHK;
      end
      mmgps_pkg::ST_OUT: begin
        out_valid_o = 1'b1;
        if (!out_stall_i) begin
          cmd_o.clear_total = 1'b1;
          state_d           = mmgps_pkg::ST_IDLE;
        end
      end
      default: state_d = mmgps_pkg::ST_IDLE;
    endcase
  end

endmodule

`default_nettype wire

/* rtl/core/mmgps_dp.sv */
// ----------------------------------------------------------------------------
// mmgps_dp
// Datapath: position store, counters, search bounds and greedy placement.
// ----------------------------------------------------------------------------
`default_nettype none

module mmgps_dp (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic [mmgps_pkg::POS_W-1:0]   position_i,
  input  wire logic                          last_i,
  input  wire logic                          cow_count_we_i,
  input  wire logic [mmgps_pkg::COW_W-1:0]   cow_count_i,
  input  wire mmgps_pkg::cmd_t               cmd_i,
  output mmgps_pkg::status_t                 sts_o,
  output logic      [mmgps_pkg::POS_W-1:0]   max_gap_o,
  output logic                               no_solution_o
);

  logic [mmgps_pkg::CNT_W-1:0]          total_q, k_q, k_m1, taken_q;
  logic [mmgps_pkg::COW_W-1:0]          cow_q;
  logic [mmgps_pkg::POS_W-1:0]          pos_q, prev_q, mid_q, rdata;
  logic                                 last_q;
  logic signed [mmgps_pkg::BOUND_W-1:0] low_q, high_q, mid_sum, gap_w;
  logic [mmgps_pkg::ADDR_W-1:0]         raddr, waddr;
  logic [mmgps_pkg::POS_W-1:0]          wdata;
  logic                                 we;
  logic                                 fits;

  assign k_m1 = k_q - 1'b1;

  always_comb begin
    if (cmd_i.ins_rd) begin
      raddr = k_m1[mmgps_pkg::ADDR_W-1:0];
    end else if (cmd_i.pass_start) begin
      raddr = '0;
    end else begin
      raddr = k_q[mmgps_pkg::ADDR_W-1:0];
    end
  end

  assign we    = cmd_i.ins_shift | cmd_i.ins_place;
  assign waddr = k_q[mmgps_pkg::ADDR_W-1:0];
  assign wdata = cmd_i.ins_shift ? rdata : pos_q;

  mmgps_ram #(
    .WIDTH (mmgps_pkg::POS_W),
    .DEPTH (mmgps_pkg::MAX_POINTS)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  assign mid_sum = low_q + high_q + mmgps_pkg::BOUND_W'(1);
  assign gap_w   = (low_q > 0) ? (low_q - mmgps_pkg::BOUND_W'(1)) : '0;
  assign fits    = 32'(taken_q) >= 32'(cow_q);

  assign sts_o.full         = total_q == mmgps_pkg::CNT_W'(mmgps_pkg::MAX_POINTS);
  assign sts_o.k_zero       = k_q == '0;
  assign sts_o.rd_gt_pos    = rdata > pos_q;
  assign sts_o.last         = last_q;
  assign sts_o.cow_gt_total = 32'(cow_q) > 32'(total_q);
  assign sts_o.low_le_high  = low_q <= high_q;
  assign sts_o.more         = k_q < total_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q <= '0;
      cow_q   <= mmgps_pkg::COW_W'(mmgps_pkg::COW_RESET);
    end else begin
      if (cow_count_we_i) begin
        cow_q <= cow_count_i;
      end
      if (cmd_i.ins_place) begin
        total_q <= total_q + 1'b1;
      end else if (cmd_i.clear_total) begin
        total_q <= '0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      pos_q  <= position_i;
      last_q <= last_i;
    end
    if (cmd_i.ins_start) begin
      k_q <= total_q;
    end else if (cmd_i.ins_shift) begin
      k_q <= k_m1;
    end else if (cmd_i.pass_start) begin
      k_q <= mmgps_pkg::CNT_W'(1);
    end else if (cmd_i.pass_adv) begin
      k_q <= k_q + 1'b1;
    end
    if (cmd_i.search_init) begin
      low_q  <= '0;
      high_q <= mmgps_pkg::BOUND_W'(mmgps_pkg::GAP_LIMIT);
    end else if (cmd_i.pass_end) begin
      if (fits) begin
        low_q <= mmgps_pkg::BOUND_W'(mid_q) + mmgps_pkg::BOUND_W'(1);
      end else begin
        high_q <= mmgps_pkg::BOUND_W'(mid_q) - mmgps_pkg::BOUND_W'(1);
      end
    end
    if (cmd_i.mid_load) begin
      mid_q <= mid_sum[mmgps_pkg::POS_W:1];
    end
    if (cmd_i.pass_first) begin
      prev_q  <= rdata;
      taken_q <= mmgps_pkg::CNT_W'(1);
    end else if (cmd_i.pass_run && ((rdata - prev_q) >= mid_q)) begin
      prev_q  <= rdata;
      taken_q <= taken_q + 1'b1;
    end
    if (cmd_i.set_none) begin
      max_gap_o     <= '0;
      no_solution_o <= 1'b1;
    end else if (cmd_i.set_gap) begin
      max_gap_o     <= gap_w[mmgps_pkg::POS_W-1:0];
      no_solution_o <= 1'b0;
    end
  end

endmodule

`default_nettype wire

/* rtl/core/max_min_gap_placement_search.sv */
// ----------------------------------------------------------------------------
// max_min_gap_placement_search
// Collects positions, keeps them sorted and finds the largest minimum gap.
// ----------------------------------------------------------------------------
//  Channel   Signals                                 Direction
//  input     in_valid_i, in_stall_o, position_i,     in
//            last_i
//  output    out_valid_o, out_stall_i, max_gap_o,    out
//            no_solution_o
//  config    cow_count_we_i, cow_count_i             in
//
// Each position is inserted into the sorted store by scanning down from the top
// entry, with one RAM read and one write per entry shifted up.
// A last transaction then runs about 30 greedy passes of a binary search over
// the gap, one store read per cycle, unless the cow count exceeds the total.
// Reset empties the store count; no clearing pass is needed.
// The result stays on the output until taken; input stalls meanwhile.
// ----------------------------------------------------------------------------
`default_nettype none

module max_min_gap_placement_search (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        in_valid_i,
  output logic                             in_stall_o,
  input  wire logic [mmgps_pkg::POS_W-1:0] position_i,
  input  wire logic                        last_i,
  output logic                             out_valid_o,
  input  wire logic                        out_stall_i,
  output logic      [mmgps_pkg::POS_W-1:0] max_gap_o,
  output logic                             no_solution_o,
  input  wire logic                        cow_count_we_i,
  input  wire logic [mmgps_pkg::COW_W-1:0] cow_count_i
);

  mmgps_pkg::cmd_t    cmd;
  mmgps_pkg::status_t sts;

  mmgps_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  mmgps_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .position_i     (position_i),
    .last_i         (last_i),
    .cow_count_we_i (cow_count_we_i),
    .cow_count_i    (cow_count_i),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .max_gap_o      (max_gap_o),
    .no_solution_o  (no_solution_o)
  );

endmodule

`default_nettype wire
